FILE: rtl/core/scg_pkg.sv
// ----------------------------------------------------------------------------
// scg_pkg
// Shared constants and helpers for the shift cipher with key guess unit.
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int NUM_LETTERS  = 26;
    localparam int LETTER_IDX_W = 5;
    localparam int CHAR_W       = 8;
    localparam int KEY_W        = 5;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

    localparam logic [LETTER_IDX_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [LETTER_IDX_W-1:0] LETTERS_N   = 5'd26;

    // Configuration register indexes.
    localparam logic CFG_SHIFT_KEY   = 1'b0;
    localparam logic CFG_CIPHER_MODE = 1'b1;

    // Negation modulo 26 of a value in 0..25.
    function automatic logic [LETTER_IDX_W-1:0] neg_mod26(
        input logic [LETTER_IDX_W-1:0] v
    );
        logic [LETTER_IDX_W-1:0] r;
        r = (v == '0) ? '0 : LETTERS_N - v;
        return r;
    endfunction

endpackage

FILE: rtl/core/scg_ram.sv
// ----------------------------------------------------------------------------
// scg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scg_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/shift_cipher_with_key_guess_unit.sv
// ----------------------------------------------------------------------------
// shift_cipher_with_key_guess_unit
// Shift cipher on a byte stream with a letter histogram and a key guess.
// ----------------------------------------------------------------------------
// Each accepted byte passes through S_IDLE, where the request is taken and, for
// a letter, its histogram bin is read from the 26-entry count RAM, and S_RMW,
// where, once the output register is free, the count is incremented and written
// back while the transformed byte goes to the output register. A byte marked
// with tlast is followed by a scan of the RAM, one bin per cycle, and by S_GUESS,
// which shows the key guess once the output is free. The count RAM has a single,
// registered read port. A new byte is accepted while a finished result still
// waits on the output. Bins carry valid bits cleared at reset and after every
// guess, so no clearing pass is needed. Counts saturate at 2^COUNT_WIDTH - 1.
// The key register is taken modulo 26.
module shift_cipher_with_key_guess_unit
    import scg_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port.
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_addr,
    input  logic [KEY_W-1:0]        i_cfg_wdata,
    // Text input.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [CHAR_W-1:0]       s_axis_tdata,  // [7:0] char_in
    input  logic                    s_axis_tlast,  // end_of_text
    // Result output.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // [7:0] out_char, [12:8] key_guess,
                                                   // [13] no_letters, [15:14] zero
    output logic                    m_axis_tuser,  // is_guess
    output logic                    m_axis_tlast   // run_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RMW   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_GUESS = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration.
    logic [KEY_W-1:0] r_shift_key;
    logic             r_cipher_mode;

    // Control.
    logic [1:0]              r_state, n_state;
    logic                    r_eot, n_eot;
    logic                    r_letter, n_letter;
    logic [LETTER_IDX_W-1:0] r_idx, n_idx;
    logic [CHAR_W-1:0]       r_char, n_char;
    logic [NUM_LETTERS-1:0]  r_cnt_vld, n_cnt_vld;
    logic [LETTER_IDX_W-1:0] r_scan_addr, n_scan_addr;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [LETTER_IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [COUNT_WIDTH-1:0]  r_best_cnt, n_best_cnt;
    logic [LETTER_IDX_W-1:0] r_best_idx, n_best_idx;

    // Output register.
    logic                   r_mvalid, n_mvalid;
    logic [OUT_TDATA_W-1:0] r_mdata, n_mdata;
    logic                   r_muser, n_muser;
    logic                   r_mlast, n_mlast;

    // RAM interface.
    logic                    ram_we;
    logic [LETTER_IDX_W-1:0] ram_waddr;
    logic [COUNT_WIDTH-1:0]  ram_wdata;
    logic                    ram_re;
    logic [LETTER_IDX_W-1:0] ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_rdata;

    // Datapath helpers.
    logic [LETTER_IDX_W-1:0] key_mod;
    logic [LETTER_IDX_W-1:0] shift_amt;
    logic                    in_upper, in_lower, in_letter;
    logic [CHAR_W-1:0]       in_base;
    logic [LETTER_IDX_W:0]   idx_sum;
    logic [LETTER_IDX_W-1:0] in_idx;
    logic                    in_acc;
    logic                    out_free;
    logic [COUNT_WIDTH-1:0]  rmw_cnt;
    logic [COUNT_WIDTH-1:0]  scan_cnt;
    logic [LETTER_IDX_W-1:0] guess;
    logic                    none;

    scg_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_LETTERS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_mvalid || m_axis_tready;

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;
    assign m_axis_tlast  = r_mlast;

    // Letter transform of the incoming byte.
    always_comb begin
        key_mod   = (r_shift_key >= LETTERS_N) ? r_shift_key - LETTERS_N : r_shift_key;
        shift_amt = r_cipher_mode ? neg_mod26(key_mod) : key_mod;
        in_upper  = (s_axis_tdata >= ASCII_UPPER_A) && (s_axis_tdata <= ASCII_UPPER_Z);
        in_lower  = (s_axis_tdata >= ASCII_LOWER_A) && (s_axis_tdata <= ASCII_LOWER_Z);
        in_letter = in_upper || in_lower;
        in_base   = in_upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        idx_sum   = {1'b0, LETTER_IDX_W'(s_axis_tdata - in_base)} + {1'b0, shift_amt};
        in_idx    = (idx_sum >= {1'b0, LETTERS_N}) ? LETTER_IDX_W'(idx_sum - {1'b0, LETTERS_N})
                                                   : idx_sum[LETTER_IDX_W-1:0];
    end

    // Bins that were not written since the last clear read as zero.
    assign rmw_cnt  = r_cnt_vld[r_idx] ? ram_rdata : '0;
    assign scan_cnt = r_cnt_vld[r_cmp_idx] ? ram_rdata : '0;
    assign none     = (r_best_cnt == '0);
    assign guess    = none ? '0 : (r_cipher_mode ? neg_mod26(r_best_idx) : r_best_idx);

    always_comb begin
        n_state     = r_state;
        n_eot       = r_eot;
        n_letter    = r_letter;
        n_idx       = r_idx;
        n_char      = r_char;
        n_cnt_vld   = r_cnt_vld;
        n_scan_addr = r_scan_addr;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_scan_addr;
        n_best_cnt  = r_best_cnt;
        n_best_idx  = r_best_idx;
        n_mvalid    = r_mvalid && !m_axis_tready;
        n_mdata     = r_mdata;
        n_muser     = r_muser;
        n_mlast     = r_mlast;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = (rmw_cnt == COUNT_MAX) ? rmw_cnt : rmw_cnt + 1'b1;
        ram_re      = 1'b0;
        ram_raddr   = in_idx;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_eot    = s_axis_tlast;
                    n_letter = in_letter;
                    n_idx    = in_idx;
                    n_char   = in_letter ? in_base + CHAR_W'(in_idx) : s_axis_tdata;
                    ram_re   = in_letter;
                    n_state  = S_RMW;
                end
            end
            S_RMW: begin
                if (out_free) begin
                    ram_we   = r_letter;
                    if (r_letter) begin
                        n_cnt_vld[r_idx] = 1'b1;
                    end
                    n_mvalid = 1'b1;
                    n_mdata  = {{(OUT_TDATA_W-CHAR_W){1'b0}}, r_char};
                    n_muser  = 1'b0;
                    n_mlast  = !r_eot;
                    if (r_eot) begin
                        n_scan_addr = '0;
                        n_best_cnt  = '0;
                        n_best_idx  = '0;
                        n_state     = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                // Reads run one bin ahead of the compare.
                if (r_scan_addr < LETTERS_N) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_scan_addr;
                    n_cmp_vld   = 1'b1;
                    n_scan_addr = r_scan_addr + 1'b1;
                end
                if (r_cmp_vld) begin
                    // Strictly greater, so ties keep the lowest letter.
                    if (scan_cnt > r_best_cnt) begin
                        n_best_cnt = scan_cnt;
                        n_best_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST_LETTER) begin
                        n_state = S_GUESS;
                    end
                end
            end
            S_GUESS: begin
                if (out_free) begin
                    n_mvalid  = 1'b1;
                    n_mdata   = {{(OUT_TDATA_W-CHAR_W-LETTER_IDX_W-1){1'b0}},
                                 none, guess, {CHAR_W{1'b0}}};
                    n_muser   = 1'b1;
                    n_mlast   = 1'b1;
                    n_cnt_vld = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_key   <= '0;
            r_cipher_mode <= 1'b0;
            r_state       <= S_IDLE;
            r_cnt_vld     <= '0;
            r_cmp_vld     <= 1'b0;
            r_mvalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SHIFT_KEY:   r_shift_key   <= i_cfg_wdata;
                    CFG_CIPHER_MODE: r_cipher_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_state   <= n_state;
            r_cnt_vld <= n_cnt_vld;
            r_cmp_vld <= n_cmp_vld;
            r_mvalid  <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eot       <= n_eot;
        r_letter    <= n_letter;
        r_idx       <= n_idx;
        r_char      <= n_char;
        r_scan_addr <= n_scan_addr;
        r_cmp_idx   <= n_cmp_idx;
        r_best_cnt  <= n_best_cnt;
        r_best_idx  <= n_best_idx;
        r_mdata     <= n_mdata;
        r_muser     <= n_muser;
        r_mlast     <= n_mlast;
    end

`ifndef SYNTHESIS
    // Only one item is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous item in work");

    // A guess result is always the last result of its item.
    a_guess_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("malformed guess result");

    // With no letters the guess is forced to zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[12:8] == 5'd0)
        else $error("key guess not zero without letters");

    // The histogram is fully cleared once a guess has been loaded.
    a_clear_after_guess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GUESS && out_free |=> r_cnt_vld == '0)
        else $error("histogram not cleared after guess");

    // Scan read pointer never runs beyond one past the last bin.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_scan_addr <= LETTERS_N)
        else $error("scan address out of range");
`endif

endmodule

FILE: bench/shift_cipher_with_key_guess_unit_test.sv
// ----------------------------------------------------------------------------
// shift_cipher_with_key_guess_unit_test
// Self-checking bench for the shift cipher with key guess unit. Text bytes go
// in on the slave stream and every result is compared field by field against
// a local predictor that keeps its own key, mode and letter histogram. The
// counter width is set small (8 bits) so that saturation can be reached.
// ----------------------------------------------------------------------------
module shift_cipher_with_key_guess_unit_test
    import scg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W       = 8;
    localparam int STALL_PERCENT = 17;
    localparam int WATCHDOG_MAX  = 3000;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              is_guess;
        logic [KEY_W-1:0]  key_guess;
        logic              no_letters;
        logic              run_last;
    } t_cipher_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_addr    = CFG_SHIFT_KEY;
    logic [KEY_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // Predictor state.
    logic [KEY_W-1:0]   key_reg  = '0;
    logic               mode_reg = 1'b0;
    logic [COUNT_W-1:0] letter_hist [NUM_LETTERS];
    t_cipher_result     pending_results [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int rx_hold_left   = 0;
    bit steady_flow    = 1'b0;

    shift_cipher_with_key_guess_unit #(
        .COUNT_WIDTH (COUNT_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_in
        .s_axis_tlast  (s_axis_tlast),   // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char, [12:8] key_guess, [13] no_letters
        .m_axis_tuser  (m_axis_tuser),   // is_guess
        .m_axis_tlast  (m_axis_tlast)    // run_last
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit is_letter(input logic [CHAR_W-1:0] c);
        return (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ||
               (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z);
    endfunction

    // Works out the results of one text byte and updates the histogram.
    function automatic void predict_cipher_byte(input logic [CHAR_W-1:0] c, input logic eot);
        int             k;
        int             shift;
        int             idx;
        int             best;
        logic [CHAR_W-1:0] base;
        t_cipher_result r;
        k     = int'(key_reg) % NUM_LETTERS;
        shift = mode_reg ? (NUM_LETTERS - k) % NUM_LETTERS : k;
        r     = '0;
        r.out_char = c;
        if (is_letter(c)) begin
            base = (c <= ASCII_UPPER_Z) ? ASCII_UPPER_A : ASCII_LOWER_A;
            idx  = (int'(c - base) + shift) % NUM_LETTERS;
            r.out_char = base + CHAR_W'(idx);
            if (letter_hist[idx] != {COUNT_W{1'b1}})
                letter_hist[idx] = letter_hist[idx] + 1'b1;
        end
        r.run_last = !eot;
        pending_results.push_back(r);
        if (eot) begin
            best = 0;
            for (int i = 1; i < NUM_LETTERS; i++)
                if (letter_hist[i] > letter_hist[best])
                    best = i;
            r = '0;
            r.is_guess = 1'b1;
            r.run_last = 1'b1;
            if (letter_hist[best] == '0) begin
                r.no_letters = 1'b1;
            end else begin
                r.key_guess = KEY_W'(mode_reg ? (NUM_LETTERS - best) % NUM_LETTERS : best);
            end
            pending_results.push_back(r);
            for (int i = 0; i < NUM_LETTERS; i++)
                letter_hist[i] = '0;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_cipher_result seen;
        t_cipher_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = {m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[12:8], m_axis_tdata[13],
                    m_axis_tlast};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $realtime, seen);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_char", want.out_char, seen.out_char);
                check_field("is_guess", want.is_guess, seen.is_guess);
                check_field("key_guess", want.key_guess, seen.key_guess);
                check_field("no_letters", want.no_letters, seen.no_letters);
                check_field("run_last", want.run_last, seen.run_last);
            end
        end
    end

    // Receiver: random stalls, a steady mode, and a counted hold-off.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (steady_flow) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= STALL_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
            $display("** shift_cipher_with_key_guess_unit: FAILED **");
            $finish;
        end
    end

    // Offers one byte and waits until the request is taken.
    task automatic send_cipher_byte(input logic [CHAR_W-1:0] c, input logic eot);
        while (!steady_flow && $urandom_range(0, 99) < STALL_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_cipher_byte(c, eot);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_cipher_byte(s[i], i == s.len() - 1);
    endtask

    // Sender pause: lets every outstanding result drain.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers; only called with the unit idle.
    task automatic write_config(input logic [KEY_W-1:0] key, input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_SHIFT_KEY;
        i_cfg_wdata <= key;
        @(posedge i_clk);
        key_reg     = key;
        i_cfg_addr  <= CFG_CIPHER_MODE;
        // Upper data bits are noise for the one-bit mode register.
        i_cfg_wdata <= {KEY_W'($urandom_range(0, 15)) << 1} | KEY_W'(mode);
        @(posedge i_clk);
        mode_reg    = mode;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_non_letter();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255)); while (is_letter(c));
        return c;
    endfunction

    // One text of random length, biased toward a favorite letter so guesses vary.
    task automatic send_random_text(input int len);
        int                roll;
        bit                letterless;
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] favorite;
        letterless = ($urandom_range(0, 9) == 0);
        favorite   = ASCII_LOWER_A + CHAR_W'($urandom_range(0, NUM_LETTERS - 1));
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (letterless || roll >= 80)
                c = pick_non_letter();
            else if (roll < 35)
                c = favorite;
            else
                c = ASCII_LOWER_A + CHAR_W'($urandom_range(0, NUM_LETTERS - 1));
            // Random case on letters.
            if (is_letter(c) && $urandom_range(0, 1))
                c = c - (ASCII_LOWER_A - ASCII_UPPER_A);
            send_cipher_byte(c, i == len - 1);
        end
    endtask

    task automatic send_random_texts(input int item_budget);
        int len;
        while (item_budget > 0) begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
            if (len > item_budget)
                len = item_budget;
            send_random_text(len);
            item_budget -= len;
        end
    endtask

    task automatic test_directed();
        // Reset settings: key 0, encrypt.
        send_string("Hi");
        wait_drained();
        write_config(5'd3, 1'b0);
        send_string("AZaz");
        send_cipher_byte(8'h00, 1'b0);
        send_cipher_byte(8'hFF, 1'b0);
        send_string("@[`{z");
        wait_drained();
        // A key above 25 wraps around; decrypt with a three-way tie.
        write_config(5'd29, 1'b1);
        send_string("aBY");
        send_string("5");
        send_string("d");
        wait_drained();
        write_config(5'd0, 1'b1);
        send_string("q");
        send_string("!");
        wait_drained();
        write_config(5'd31, 1'b0);
        send_string("zZ");
    endtask

    // Letter b runs past the count limit; a wrapped count would lose to letter c.
    task automatic test_saturation();
        wait_drained();
        write_config(5'd0, 1'b0);
        for (int i = 0; i < (1 << COUNT_W) + 4; i++)
            send_cipher_byte("b", 1'b0);
        for (int i = 0; i < 10; i++)
            send_cipher_byte($urandom_range(0, 1) ? "c" : "C", 1'b0);
        send_cipher_byte(".", 1'b1);
    endtask

    task automatic test_random_settings();
        logic [KEY_W-1:0] keys [6];
        keys = '{5'd0, 5'd25, 5'd31, 5'd13, 5'd26, KEY_W'($urandom_range(0, 31))};
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_config(keys[p], p[0]);
            steady_flow = (p == 2);
            send_random_texts(40);
        end
        steady_flow = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        wait_drained();
        write_config(KEY_W'($urandom_range(0, 25)), 1'b1);
        rx_hold_left <= 200;
        send_random_texts(50);
    endtask

    initial begin
        for (int i = 0; i < NUM_LETTERS; i++)
            letter_hist[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_random_settings();
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** shift_cipher_with_key_guess_unit: PASSED **");
        end else begin
            $display("** shift_cipher_with_key_guess_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/scg_pkg.sv
rtl/core/scg_ram.sv
rtl/core/shift_cipher_with_key_guess_unit.sv
bench/shift_cipher_with_key_guess_unit_test.sv
